### src/gpc_pkg.sv
// Shared types and constants for the grid path counter.
// No dependencies; compiled first.
`default_nettype none

package gpc_pkg;

  // Configuration register layout
  localparam int CFG_W     = 4;   // width of start_row / start_col
  localparam int CFG_IDX_W = 1;
  localparam int PATH_W    = 32;  // width of the path_count field

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;

  localparam cfg_idx_t REG_START_ROW = cfg_idx_t'(0);
  localparam cfg_idx_t REG_START_COL = cfg_idx_t'(1);

  // Per-cell decisions made at input transfer, carried into the compute stage
  typedef struct packed {
    logic is_start;
    logic is_origin;
    logic row0;
    logic col0;
    logic open;
  } cell_ctl_t;

endpackage

`default_nettype wire

### src/gpc_if.sv
// Valid/ready stream interfaces for the cell input and the count output.
// Depends on gpc_pkg for the count field width.
`default_nettype none

interface gpc_in_if;
  logic valid;
  logic ready;
  logic cell_open;
  logic frame_start;

  modport source (output valid, output cell_open, output frame_start, input ready);
  modport sink   (input valid, input cell_open, input frame_start, output ready);
endinterface

interface gpc_out_if;
  import gpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [PATH_W-1:0] path_count;
  logic              saturated;

  modport source (output valid, output path_count, output saturated, input ready);
  modport sink   (input valid, input path_count, input saturated, output ready);
endinterface

`default_nettype wire

### src/gpc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module gpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/grid_path_count_with_obstacles.sv
// Top level of the grid path counter: position tracking, line buffer, saturating add.
// Depends on gpc_pkg, gpc_if (gpc_in_if, gpc_out_if) and gpc_ram.
`default_nettype none

// Counts monotone right/down paths from a configured start cell over a grid of
// ROWS x COLS cells streamed in row-major order. Every input transfer produces
// exactly one result, in order. The block sustains one cell per clock while the
// output accepts results; a cell's result is loaded into the output register
// when its compute stage advances, which a stalled output can delay. The line
// buffer's registered read feeds that stage, and the single saturating add of
// the above and left counts is combinational, ahead of the output register.
// The line buffer is a COLS-entry RAM holding the previous row; it needs no
// clearing since row 0 rewrites every column before any later row reads it.
// frame_start on a cell puts it at position (0,0). A start cell outside the
// grid gives all zeros. The user must write start_row (index 0) and start_col
// (index 1) through the cfg port only while the block is idle; the block itself
// does not enforce this.
module grid_path_count_with_obstacles #(
  parameter int ROWS       = 16,
  parameter int COLS       = 16,
  parameter int COUNT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  gpc_in_if.sink                  in_ch,
  gpc_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire gpc_pkg::cfg_idx_t  cfg_idx,
  input  wire gpc_pkg::cfg_data_t cfg_data
);

  import gpc_pkg::*;

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int CMPW = (RW > CFG_W) ? RW : CFG_W;
  localparam int HW   = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Configuration
  cfg_data_t start_row_r, start_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_row_r <= '0;
      start_col_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_ROW: start_row_r <= cfg_data;
        REG_START_COL: start_col_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv, in_xfer;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Raster position of the next cell
  logic [RW-1:0] row_r, row_nxt, r_eff;
  logic [CW-1:0] col_r, col_nxt, c_eff;

  assign r_eff = in_ch.frame_start ? '0 : row_r;
  assign c_eff = in_ch.frame_start ? '0 : col_r;

  always_comb begin
    if (c_eff == CW'(COLS - 1)) begin
      col_nxt = '0;
      row_nxt = (r_eff == RW'(ROWS - 1)) ? '0 : r_eff + RW'(1);
    end else begin
      col_nxt = c_eff + CW'(1);
      row_nxt = r_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_xfer) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Cell classification at transfer
  cell_ctl_t ctl_nxt, s1_ctl_r;
  logic [CW-1:0] s1_col_r;

  always_comb begin
    ctl_nxt.is_start  = (CMPW'(r_eff) == CMPW'(start_row_r)) &&
                        (HW'(c_eff) == HW'(start_col_r));
    ctl_nxt.row0      = (r_eff == '0);
    ctl_nxt.col0      = (c_eff == '0);
    ctl_nxt.is_origin = ctl_nxt.row0 && ctl_nxt.col0;
    ctl_nxt.open      = in_ch.cell_open;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ctl_r <= ctl_nxt;
      s1_col_r <= c_eff;
    end
  end

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Line buffer: read the cell's column at transfer, write back on advance
  logic [COUNT_BITS-1:0] above_cnt;
  logic [COUNT_BITS-1:0] count;

  gpc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (count),
    .re    (in_xfer),
    .raddr (c_eff),
    .rdata (above_cnt)
  );

  // Count of the previous cell
  logic [COUNT_BITS-1:0] left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_adv) begin
      left_r <= count;
    end
  end

  // Saturating add and cell rule selection
  logic [COUNT_BITS:0] sum;
  logic                clip;

  assign sum = {1'b0, above_cnt} + {1'b0, left_r};

  always_comb begin
    clip = 1'b0;
    if (s1_ctl_r.is_start) begin
      count = COUNT_ONE;
    end else if (s1_ctl_r.is_origin || !s1_ctl_r.open) begin
      count = '0;
    end else if (s1_ctl_r.row0) begin
      count = left_r;
    end else if (s1_ctl_r.col0) begin
      count = above_cnt;
    end else if (sum[COUNT_BITS]) begin
      count = '1;
      clip  = 1'b1;
    end else begin
      count = sum[COUNT_BITS-1:0];
    end
  end

  // Output register
  logic [PATH_W-1:0] path_r;
  logic              sat_r;

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      path_r <= PATH_W'(count);
      sat_r  <= clip;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.path_count = path_r;
  assign out_ch.saturated  = sat_r;

endmodule

`default_nettype wire
